// ===== sv/windowed_weighted_genotype_correlation_unit_defines.svh =====
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the correlation unit.
// ============================================================================
`ifndef WINDOWED_WEIGHTED_GENOTYPE_CORRELATION_UNIT_DEFINES_SVH
`define WINDOWED_WEIGHTED_GENOTYPE_CORRELATION_UNIT_DEFINES_SVH

// condition must never hold outside reset
`define WWGC_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define WWGC_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== sv/wwgc_pkg.sv =====
// ============================================================================
// wwgc_pkg
// Types and constants of the windowed weighted genotype correlation unit.
// ============================================================================
package wwgc_pkg;

    localparam int MAX_SAMPLES = 4096;
    localparam int WINDOW_COLS = 64;

    localparam int IDX_W  = $clog2(MAX_SAMPLES);
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int SLOT_W = (WINDOW_COLS > 1) ? $clog2(WINDOW_COLS) : 1;
    localparam int FILL_W = $clog2(WINDOW_COLS + 1);
    localparam int K_W    = $clog2(WINDOW_COLS + 2);

    localparam int SUM_W  = IDX_W + 18;
    localparam int PROD_W = 2 * SUM_W;
    localparam int RAD_W  = 4 * SUM_W;
    localparam int ROOT_W = PROD_W;
    localparam int ITER_W = $clog2(ROOT_W);
    localparam int Q_W    = 16;

    localparam int SAMPLE_DEPTH = 2 ** IDX_W;
    localparam int META_DEPTH   = 2 ** SLOT_W;
    localparam int RING_DEPTH   = (2 ** SLOT_W) * (2 ** IDX_W);
    localparam int META_W       = 32 + CNT_W;

    localparam logic [1:0]     GENO_MISSING = 2'd3;
    localparam logic [Q_W-1:0] CORR_POS_MAX = 16'h7FFF;

    localparam logic CFG_WINDOW_SPAN  = 1'b0;
    localparam logic CFG_R2_THRESHOLD = 1'b1;
    localparam logic [15:0] R2_THRESHOLD_RESET = 16'd13107;

    typedef struct packed {
        logic [1:0]  genotype;
        logic [15:0] sample_weight;
        logic [31:0] column_position;
        logic        last_sample;
    } in_word_t;

    typedef struct packed {
        logic [31:0]        neighbour_number;
        logic signed [15:0] correlation;
        logic               pair_found;
        logic               window_truncated;
        logic               last_result;
    } out_word_t;

    typedef struct packed {
        logic [SUM_W-1:0] w;
        logic [SUM_W-1:0] sx;
        logic [SUM_W-1:0] sxx;
        logic [SUM_W-1:0] sy;
        logic [SUM_W-1:0] syy;
        logic [SUM_W-1:0] sxy;
    } sums_t;

    typedef struct packed {
        logic               report;
        logic signed [15:0] correlation;
    } corr_res_t;

    typedef enum logic [3:0] {
        ST_IN,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_WALK,
        ST_META_RD,
        ST_META_CHK,
        ST_SUM,
        ST_CORR_GO,
        ST_CORR_WAIT,
        ST_PUSH,
        ST_FINAL,
        ST_COPY,
        ST_COMMIT
    } top_state_t;

    typedef enum logic [2:0] {
        C_IDLE,
        C_MUL,
        C_DIFF,
        C_WIDE,
        C_SQRT,
        C_DIV,
        C_JUDGE
    } corr_state_t;

endpackage

// ===== sv/wwgc_ram.sv =====
// ============================================================================
// wwgc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ============================================================================
module wwgc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/wwgc_corr.sv =====
// ============================================================================
// wwgc_corr
// Pearson r of one column pair from its weighted sums: shared multiplier,
// bit-serial square root and restoring divider, threshold compare.
// ============================================================================
module wwgc_corr (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  wwgc_pkg::sums_t   sums,
    input  logic [15:0]       r2_threshold,
    output logic              done,
    output wwgc_pkg::corr_res_t result
);

    localparam int SUM_W  = wwgc_pkg::SUM_W;
    localparam int PROD_W = wwgc_pkg::PROD_W;
    localparam int RAD_W  = wwgc_pkg::RAD_W;
    localparam int ROOT_W = wwgc_pkg::ROOT_W;
    localparam int ITER_W = wwgc_pkg::ITER_W;
    localparam int Q_W    = wwgc_pkg::Q_W;

    wwgc_pkg::corr_state_t state_reg, state_next;

    logic [4:0]        step_reg, step_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic [PROD_W-1:0] mul_reg, mul_next;
    logic [PROD_W-1:0] prod_reg [6];
    logic [PROD_W-1:0] prod_next [6];
    logic              neg_reg, neg_next;
    logic [PROD_W-1:0] absn_reg, absn_next;
    logic [PROD_W-1:0] dx_reg, dx_next;
    logic [PROD_W-1:0] dy_reg, dy_next;
    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [ROOT_W:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [ROOT_W:0]   drem_reg, drem_next;
    logic [Q_W-1:0]    quo_reg, quo_next;

    logic [SUM_W-1:0]  mul_a;
    logic [SUM_W-1:0]  mul_b;
    logic [4:0]        step_prev;
    logic [ROOT_W+1:0] rem_sh;
    logic [ROOT_W+1:0] trial;
    logic [ROOT_W:0]   div_sh;
    logic              div_ge;
    logic [2*Q_W-1:0]  q_sq;

    assign step_prev = step_reg - 5'd1;
    assign rem_sh    = {rem_reg[ROOT_W-1:0], rad_reg[RAD_W-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign div_sh    = (step_reg == 5'd0) ? drem_reg : {drem_reg[ROOT_W-1:0], 1'b0};
    assign div_ge    = div_sh >= {1'b0, root_reg};
    assign q_sq      = (2*Q_W)'(quo_reg) * (2*Q_W)'(quo_reg);

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == wwgc_pkg::C_MUL)
        begin
            unique case (step_reg)
                5'd0:    begin mul_a = sums.w;  mul_b = sums.sxy; end
                5'd1:    begin mul_a = sums.sx; mul_b = sums.sy;  end
                5'd2:    begin mul_a = sums.w;  mul_b = sums.sxx; end
                5'd3:    begin mul_a = sums.sx; mul_b = sums.sx;  end
                5'd4:    begin mul_a = sums.w;  mul_b = sums.syy; end
                5'd5:    begin mul_a = sums.sy; mul_b = sums.sy;  end
                default: begin mul_a = '0;      mul_b = '0;       end
            endcase
        end
        else if (state_reg == wwgc_pkg::C_WIDE)
        begin
            mul_a = step_reg[1] ? dx_reg[PROD_W-1:SUM_W] : dx_reg[SUM_W-1:0];
            mul_b = step_reg[0] ? dy_reg[PROD_W-1:SUM_W] : dy_reg[SUM_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wwgc_pkg::C_IDLE:  if (start) state_next = wwgc_pkg::C_MUL;
            wwgc_pkg::C_MUL:   if (step_reg == 5'd6) state_next = wwgc_pkg::C_DIFF;
            wwgc_pkg::C_DIFF:  state_next = wwgc_pkg::C_WIDE;
            wwgc_pkg::C_WIDE:  if (step_reg == 5'd4) state_next = wwgc_pkg::C_SQRT;
            wwgc_pkg::C_SQRT:  if (iter_reg == '0) state_next = wwgc_pkg::C_DIV;
            wwgc_pkg::C_DIV:   if (step_reg == 5'(Q_W - 1)) state_next = wwgc_pkg::C_JUDGE;
            wwgc_pkg::C_JUDGE: state_next = wwgc_pkg::C_IDLE;
            default:           state_next = wwgc_pkg::C_IDLE;
        endcase
    end

    always_comb
    begin
        step_next = step_reg + 5'd1;
        iter_next = iter_reg;
        mul_next  = mul_a * mul_b;
        prod_next = prod_reg;
        neg_next  = neg_reg;
        absn_next = absn_reg;
        dx_next   = dx_reg;
        dy_next   = dy_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        drem_next = drem_reg;
        quo_next  = quo_reg;
        unique case (state_reg)
            wwgc_pkg::C_IDLE:
            begin
                step_next = '0;
            end
            wwgc_pkg::C_MUL:
            begin
                if (step_reg != 5'd0)
                begin
                    prod_next[step_prev[2:0]] = mul_reg;
                end
            end
            wwgc_pkg::C_DIFF:
            begin
                neg_next  = prod_reg[1] > prod_reg[0];
                absn_next = neg_next ? prod_reg[1] - prod_reg[0] : prod_reg[0] - prod_reg[1];
                dx_next   = prod_reg[2] - prod_reg[3];
                dy_next   = prod_reg[4] - prod_reg[5];
                rad_next  = '0;
                step_next = '0;
            end
            wwgc_pkg::C_WIDE:
            begin
                if (step_reg != 5'd0)
                begin
                    unique case (step_prev[1:0])
                        2'd0:       rad_next = rad_reg + RAD_W'(mul_reg);
                        2'd1, 2'd2: rad_next = rad_reg + (RAD_W'(mul_reg) << SUM_W);
                        2'd3:       rad_next = rad_reg + (RAD_W'(mul_reg) << (2 * SUM_W));
                        default:    rad_next = rad_reg;
                    endcase
                end
                rem_next  = '0;
                root_next = '0;
                iter_next = ITER_W'(ROOT_W - 1);
            end
            wwgc_pkg::C_SQRT:
            begin
                if (rem_sh >= trial)
                begin
                    rem_next  = (ROOT_W+1)'(rem_sh - trial);
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = (ROOT_W+1)'(rem_sh);
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                rad_next  = rad_reg << 2;
                iter_next = iter_reg - ITER_W'(1);
                drem_next = {1'b0, absn_reg};
                quo_next  = '0;
                step_next = '0;
            end
            wwgc_pkg::C_DIV:
            begin
                drem_next = div_ge ? div_sh - {1'b0, root_reg} : div_sh;
                quo_next  = {quo_reg[Q_W-2:0], div_ge};
            end
            wwgc_pkg::C_JUDGE:
            begin
                step_next = '0;
            end
            default:
            begin
                step_next = '0;
            end
        endcase
    end

    always_comb
    begin
        done               = state_reg == wwgc_pkg::C_JUDGE;
        result.report      = (root_reg != '0) && (q_sq > (2*Q_W)'({r2_threshold, 14'b0}));
        result.correlation = neg_reg ? $signed(Q_W'(~quo_reg + Q_W'(1)))
                           : $signed(quo_reg[Q_W-1] ? wwgc_pkg::CORR_POS_MAX : quo_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wwgc_pkg::C_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        iter_reg <= iter_next;
        mul_reg  <= mul_next;
        prod_reg <= prod_next;
        neg_reg  <= neg_next;
        absn_reg <= absn_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        drem_reg <= drem_next;
        quo_reg  <= quo_next;
    end

endmodule

// ===== sv/windowed_weighted_genotype_correlation_unit.sv =====
// Samples are taken one per cycle while a column streams in. After the last
// sample of a column the unit scans the stored column positions back from
// the newest, then for each in-window neighbour reads the genotype ring
// memory once per sample to form the weighted sums, then runs the shared
// 30x30 multiplier, a 60-step square root and a 16-step divider. Results
// leave through a one-word output register, and the column is then copied
// into the ring. No new sample is taken until that copy is committed.
// ============================================================================
// windowed_weighted_genotype_correlation_unit
// Windowed weighted Pearson correlation of genotype columns against a ring
// of earlier columns held in synchronous memories.
// ============================================================================
`include "windowed_weighted_genotype_correlation_unit_defines.svh"

module windowed_weighted_genotype_correlation_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  wwgc_pkg::in_word_t    in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output wwgc_pkg::out_word_t   out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [31:0]           cfg_data
);

    localparam int IDX_W  = wwgc_pkg::IDX_W;
    localparam int CNT_W  = wwgc_pkg::CNT_W;
    localparam int SLOT_W = wwgc_pkg::SLOT_W;
    localparam int FILL_W = wwgc_pkg::FILL_W;
    localparam int K_W    = wwgc_pkg::K_W;
    localparam int SUM_W  = wwgc_pkg::SUM_W;
    localparam int WCOLS  = wwgc_pkg::WINDOW_COLS;

    wwgc_pkg::top_state_t state_reg, state_next;

    logic [31:0]       span_reg, span_next;
    logic [15:0]       thr_reg, thr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [31:0]       cur_pos_reg, cur_pos_next;
    logic [SLOT_W-1:0] head_reg, head_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              dropped_reg, dropped_next;
    logic [31:0]       seen_reg, seen_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic [K_W-1:0]    m_reg, m_next;
    logic              trunc_reg, trunc_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic              rd_pend_reg, rd_pend_next;
    wwgc_pkg::sums_t   sums_reg, sums_next;
    wwgc_pkg::corr_res_t res_reg, res_next;
    logic              pend_valid_reg, pend_valid_next;
    wwgc_pkg::out_word_t pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;
    wwgc_pkg::out_word_t out_reg, out_next;

    logic              in_acc;
    logic              out_free;
    logic [SLOT_W-1:0] slot;
    logic [K_W:0]      slot_wide;
    logic [CNT_W-1:0]  i_prev;
    logic              in_win;
    logic [31:0]       meta_pos;
    logic [CNT_W-1:0]  meta_len;
    wwgc_pkg::top_state_t adv_state;
    wwgc_pkg::out_word_t  item;

    logic                      cur_we;
    logic                      wt_we;
    logic                      ring_we;
    logic                      meta_we;
    logic [1:0]                cur_rdata;
    logic [15:0]               wt_rdata;
    logic [1:0]                ring_rdata;
    logic [wwgc_pkg::META_W-1:0] meta_rdata;

    logic                 corr_start;
    logic                 corr_done;
    wwgc_pkg::corr_res_t  corr_res;

    function automatic logic [SUM_W-1:0] scale(input logic [15:0] w, input logic [2:0] m);
        logic [SUM_W-1:0] r;
        unique case (m)
            3'd1:    r = SUM_W'(w);
            3'd2:    r = SUM_W'(w) << 1;
            3'd4:    r = SUM_W'(w) << 2;
            default: r = '0;
        endcase
        return r;
    endfunction

    assign in_acc   = in_valid && in_ready;
    assign in_ready = state_reg == wwgc_pkg::ST_IN;
    assign cfg_ready = 1'b1;
    assign out_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign i_prev   = i_reg - CNT_W'(1);

    assign slot_wide = ((K_W+1)'(head_reg) >= (K_W+1)'(k_reg))
                     ? (K_W+1)'(head_reg) - (K_W+1)'(k_reg)
                     : (K_W+1)'(head_reg) + (K_W+1)'(WCOLS) - (K_W+1)'(k_reg);
    assign slot      = slot_wide[SLOT_W-1:0];

    assign meta_pos = meta_rdata[wwgc_pkg::META_W-1 -: 32];
    assign meta_len = meta_rdata[CNT_W-1:0];
    assign in_win   = ({1'b0, meta_pos} + {1'b0, span_reg}) >= {1'b0, cur_pos_reg};

    assign adv_state = (k_reg == m_reg) ? wwgc_pkg::ST_FINAL : wwgc_pkg::ST_META_RD;

    always_comb
    begin
        item.neighbour_number = seen_reg - 32'(k_reg) + 32'd1;
        item.correlation      = res_reg.correlation;
        item.pair_found       = 1'b1;
        item.window_truncated = trunc_reg;
        item.last_result      = 1'b0;
    end

    wwgc_ram #(.WIDTH(2), .DEPTH(wwgc_pkg::SAMPLE_DEPTH)) u_cur_ram (
        .clk   (clk),
        .we    (cur_we),
        .waddr (cnt_reg[IDX_W-1:0]),
        .wdata (in_data.genotype),
        .raddr (i_reg[IDX_W-1:0]),
        .rdata (cur_rdata)
    );

    wwgc_ram #(.WIDTH(16), .DEPTH(wwgc_pkg::SAMPLE_DEPTH)) u_wt_ram (
        .clk   (clk),
        .we    (wt_we),
        .waddr (cnt_reg[IDX_W-1:0]),
        .wdata (in_data.sample_weight),
        .raddr (i_reg[IDX_W-1:0]),
        .rdata (wt_rdata)
    );

    wwgc_ram #(.WIDTH(2), .DEPTH(wwgc_pkg::RING_DEPTH)) u_ring_ram (
        .clk   (clk),
        .we    (ring_we),
        .waddr ({head_reg, i_prev[IDX_W-1:0]}),
        .wdata (cur_rdata),
        .raddr ({slot, i_reg[IDX_W-1:0]}),
        .rdata (ring_rdata)
    );

    wwgc_ram #(.WIDTH(wwgc_pkg::META_W), .DEPTH(wwgc_pkg::META_DEPTH)) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (head_reg),
        .wdata ({cur_pos_reg, cnt_reg}),
        .raddr (slot),
        .rdata (meta_rdata)
    );

    wwgc_corr u_corr (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (corr_start),
        .sums         (sums_reg),
        .r2_threshold (thr_reg),
        .done         (corr_done),
        .result       (corr_res)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wwgc_pkg::ST_IN:
                if (in_acc && in_data.last_sample) state_next = wwgc_pkg::ST_SCAN_RD;
            wwgc_pkg::ST_SCAN_RD:
                state_next = (k_reg > K_W'(fill_reg)) ? wwgc_pkg::ST_WALK
                                                      : wwgc_pkg::ST_SCAN_CHK;
            wwgc_pkg::ST_SCAN_CHK:
                state_next = in_win ? wwgc_pkg::ST_SCAN_RD : wwgc_pkg::ST_WALK;
            wwgc_pkg::ST_WALK:
                state_next = (m_reg == '0) ? wwgc_pkg::ST_FINAL : wwgc_pkg::ST_META_RD;
            wwgc_pkg::ST_META_RD:
                state_next = wwgc_pkg::ST_META_CHK;
            wwgc_pkg::ST_META_CHK:
                state_next = wwgc_pkg::ST_SUM;
            wwgc_pkg::ST_SUM:
                if (i_reg == n_reg && !rd_pend_reg) state_next = wwgc_pkg::ST_CORR_GO;
            wwgc_pkg::ST_CORR_GO:
                state_next = wwgc_pkg::ST_CORR_WAIT;
            wwgc_pkg::ST_CORR_WAIT:
                if (corr_done) state_next = corr_res.report ? wwgc_pkg::ST_PUSH : adv_state;
            wwgc_pkg::ST_PUSH:
                if (!pend_valid_reg || out_free) state_next = adv_state;
            wwgc_pkg::ST_FINAL:
                if (out_free) state_next = wwgc_pkg::ST_COPY;
            wwgc_pkg::ST_COPY:
                if (i_reg == cnt_reg && !rd_pend_reg) state_next = wwgc_pkg::ST_COMMIT;
            wwgc_pkg::ST_COMMIT:
                state_next = wwgc_pkg::ST_IN;
            default:
                state_next = wwgc_pkg::ST_IN;
        endcase
    end

    always_comb
    begin
        span_next       = span_reg;
        thr_next        = thr_reg;
        cnt_next        = cnt_reg;
        cur_pos_next    = cur_pos_reg;
        head_next       = head_reg;
        fill_next       = fill_reg;
        dropped_next    = dropped_reg;
        seen_next       = seen_reg;
        k_next          = k_reg;
        m_next          = m_reg;
        trunc_next      = trunc_reg;
        n_next          = n_reg;
        i_next          = i_reg;
        rd_pend_next    = rd_pend_reg;
        sums_next       = sums_reg;
        res_next        = res_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        cur_we          = 1'b0;
        wt_we           = 1'b0;
        ring_we         = 1'b0;
        meta_we         = 1'b0;
        corr_start      = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                wwgc_pkg::CFG_WINDOW_SPAN:  span_next = cfg_data;
                wwgc_pkg::CFG_R2_THRESHOLD: thr_next  = cfg_data[15:0];
                default:                    span_next = span_reg;
            endcase
        end

        unique case (state_reg)
            wwgc_pkg::ST_IN:
            begin
                if (in_acc)
                begin
                    if (cnt_reg == '0)
                    begin
                        cur_pos_next = in_data.column_position;
                    end
                    if (cnt_reg < CNT_W'(wwgc_pkg::MAX_SAMPLES))
                    begin
                        cur_we   = 1'b1;
                        wt_we    = 1'b1;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    k_next = K_W'(1);
                    m_next = '0;
                end
            end
            wwgc_pkg::ST_SCAN_CHK:
            begin
                if (in_win)
                begin
                    m_next = k_reg;
                    k_next = k_reg + K_W'(1);
                end
            end
            wwgc_pkg::ST_WALK:
            begin
                trunc_next = (m_reg == K_W'(WCOLS)) && dropped_reg;
                k_next     = K_W'(1);
            end
            wwgc_pkg::ST_META_CHK:
            begin
                n_next       = (cnt_reg < meta_len) ? cnt_reg : meta_len;
                i_next       = '0;
                rd_pend_next = 1'b0;
                sums_next    = '0;
            end
            wwgc_pkg::ST_SUM:
            begin
                rd_pend_next = i_reg < n_reg;
                if (i_reg < n_reg)
                begin
                    i_next = i_reg + CNT_W'(1);
                end
                if (rd_pend_reg && cur_rdata != wwgc_pkg::GENO_MISSING
                    && ring_rdata != wwgc_pkg::GENO_MISSING)
                begin
                    sums_next.w   = sums_reg.w + SUM_W'(wt_rdata);
                    sums_next.sx  = sums_reg.sx + scale(wt_rdata, 3'(cur_rdata));
                    sums_next.sxx = sums_reg.sxx
                                  + scale(wt_rdata, {cur_rdata[1], 1'b0, cur_rdata[0]});
                    sums_next.sy  = sums_reg.sy + scale(wt_rdata, 3'(ring_rdata));
                    sums_next.syy = sums_reg.syy
                                  + scale(wt_rdata, {ring_rdata[1], 1'b0, ring_rdata[0]});
                    sums_next.sxy = sums_reg.sxy
                                  + scale(wt_rdata, 3'(cur_rdata) * 3'(ring_rdata));
                end
            end
            wwgc_pkg::ST_CORR_GO:
            begin
                corr_start = 1'b1;
            end
            wwgc_pkg::ST_CORR_WAIT:
            begin
                if (corr_done)
                begin
                    res_next = corr_res;
                    if (!corr_res.report)
                    begin
                        k_next = k_reg + K_W'(1);
                    end
                end
            end
            wwgc_pkg::ST_PUSH:
            begin
                if (!pend_valid_reg)
                begin
                    pend_valid_next = 1'b1;
                    pend_next       = item;
                    k_next          = k_reg + K_W'(1);
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = pend_reg;
                    pend_next      = item;
                    k_next         = k_reg + K_W'(1);
                end
            end
            wwgc_pkg::ST_FINAL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_next = pend_reg;
                    end
                    else
                    begin
                        out_next.neighbour_number = '0;
                        out_next.correlation      = '0;
                        out_next.pair_found       = 1'b0;
                        out_next.window_truncated = trunc_reg;
                    end
                    out_next.last_result = 1'b1;
                    pend_valid_next      = 1'b0;
                    i_next               = '0;
                    rd_pend_next         = 1'b0;
                end
            end
            wwgc_pkg::ST_COPY:
            begin
                rd_pend_next = i_reg < cnt_reg;
                if (i_reg < cnt_reg)
                begin
                    i_next = i_reg + CNT_W'(1);
                end
                ring_we = rd_pend_reg;
            end
            wwgc_pkg::ST_COMMIT:
            begin
                meta_we   = 1'b1;
                head_next = (head_reg == SLOT_W'(WCOLS - 1)) ? '0 : head_reg + SLOT_W'(1);
                if (fill_reg < FILL_W'(WCOLS))
                begin
                    fill_next = fill_reg + FILL_W'(1);
                end
                else
                begin
                    dropped_next = 1'b1;
                end
                seen_next = seen_reg + 32'd1;
                cnt_next  = '0;
            end
            default:
            begin
                corr_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= wwgc_pkg::ST_IN;
            span_reg       <= '0;
            thr_reg        <= wwgc_pkg::R2_THRESHOLD_RESET;
            cnt_reg        <= '0;
            head_reg       <= '0;
            fill_reg       <= '0;
            dropped_reg    <= 1'b0;
            seen_reg       <= '0;
            k_reg          <= '0;
            m_reg          <= '0;
            rd_pend_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            span_reg       <= span_next;
            thr_reg        <= thr_next;
            cnt_reg        <= cnt_next;
            head_reg       <= head_next;
            fill_reg       <= fill_next;
            dropped_reg    <= dropped_next;
            seen_reg       <= seen_next;
            k_reg          <= k_next;
            m_reg          <= m_next;
            rd_pend_reg    <= rd_pend_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_pos_reg <= cur_pos_next;
        trunc_reg   <= trunc_next;
        n_reg       <= n_next;
        i_reg       <= i_next;
        sums_reg    <= sums_next;
        res_reg     <= res_next;
        pend_reg    <= pend_next;
        out_reg     <= out_next;
    end

    `WWGC_ASSERT_IMPLY(a_done_in_wait, corr_done, state_reg == wwgc_pkg::ST_CORR_WAIT, "correlation result outside wait state")
    `WWGC_ASSERT_NEVER(a_cnt_bound, cnt_reg > CNT_W'(wwgc_pkg::MAX_SAMPLES), "sample count beyond limit")
    `WWGC_ASSERT_IMPLY(a_drop_full, dropped_reg, fill_reg == FILL_W'(WCOLS), "ring dropped while not full")
    `WWGC_ASSERT_IMPLY(a_no_pend_in, in_acc, !pend_valid_reg, "sample taken with a result still held")

endmodule

// ===== dv/tb.sv =====
// ============================================================================
// Windowed genotype correlation unit testbench
// Streams genotype columns and checks each reported pair, or the no-match
// word, against an in-bench integer predictor. Both handshake sides idle at
// random. The run covers several window and threshold settings.
// ============================================================================
`timescale 1ns / 1ps

module tb;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int N_ROWS         = 15;

    typedef struct {
        wwgc_pkg::in_word_t  word;
        bit                  typed;
        wwgc_pkg::out_word_t want;
    } row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    wwgc_pkg::in_word_t  in_data;
    logic                out_valid;
    logic                out_ready;
    wwgc_pkg::out_word_t out_data;
    logic                cfg_valid;
    logic                cfg_ready;
    logic                cfg_index;
    logic [31:0]         cfg_data;

    windowed_weighted_genotype_correlation_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [31:0] span_reg;
    logic [15:0] thr_reg;
    logic [1:0]  ring_geno [wwgc_pkg::WINDOW_COLS][wwgc_pkg::MAX_SAMPLES];
    int unsigned ring_len [wwgc_pkg::WINDOW_COLS];
    logic [31:0] ring_pos [wwgc_pkg::WINDOW_COLS];
    logic [15:0] weights [wwgc_pkg::MAX_SAMPLES];
    logic [1:0]  cur_geno [wwgc_pkg::MAX_SAMPLES];
    logic [31:0] cur_pos;
    logic [31:0] col_count;
    int unsigned samp_cnt;
    int unsigned head;
    int unsigned fill;
    bit          dropped;

    wwgc_pkg::out_word_t col_words [$];
    wwgc_pkg::out_word_t expected_words [$];
    int          errors;
    int          quiet_in;
    int          quiet_out;
    int          items;
    logic [1:0]  prev_geno [32];
    row_t        rows [N_ROWS];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        begin
            errors++;
            if (errors <= 40)
                $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
        end
    endtask

    function automatic bit pair_corr(int unsigned slot, output int unsigned q,
                                     output bit neg);
        logic [63:0]  sw, sx, sxx, sy, syy, sxy, x, y, w;
        logic [63:0]  absn, dx, dy, s, c;
        logic [127:0] a, b, rad, t, quo;
        int unsigned  n;
        begin
            sw = 0; sx = 0; sxx = 0; sy = 0; syy = 0; sxy = 0;
            n = (samp_cnt < ring_len[slot]) ? samp_cnt : ring_len[slot];
            for (int unsigned i = 0; i < n; i++)
            begin
                x = 64'(cur_geno[i]);
                y = 64'(ring_geno[slot][i]);
                w = 64'(weights[i]);
                if (cur_geno[i] != wwgc_pkg::GENO_MISSING
                    && ring_geno[slot][i] != wwgc_pkg::GENO_MISSING)
                begin
                    sw += w; sx += x * w; sxx += x * x * w;
                    sy += y * w; syy += y * y * w; sxy += x * y * w;
                end
            end
            a = 128'(sw) * 128'(sxy);
            b = 128'(sx) * 128'(sy);
            neg = (b > a);
            absn = neg ? 64'(b - a) : 64'(a - b);
            dx = 64'(128'(sw) * 128'(sxx) - 128'(sx) * 128'(sx));
            dy = 64'(128'(sw) * 128'(syy) - 128'(sy) * 128'(sy));
            rad = 128'(dx) * 128'(dy);
            s = 0;
            for (int k = 63; k >= 0; k--)
            begin
                c = s | (64'd1 << k);
                if (128'(c) * 128'(c) <= rad)
                    s = c;
            end
            if (s == 0)
                return 1'b0;
            t = 128'(absn) << 15;
            quo = t / 128'(s);
            q = (quo > 128'd32768) ? 32768 : int'(quo);
            return 1'b1;
        end
    endfunction

    function automatic void take_word(wwgc_pkg::in_word_t wd);
        longint      pos_min;
        int unsigned slot;
        int unsigned q;
        int unsigned mag;
        bit          neg;
        bit          trunc;
        wwgc_pkg::out_word_t o;
        begin
            col_words.delete();
            if (samp_cnt == 0)
                cur_pos = wd.column_position;
            if (samp_cnt < wwgc_pkg::MAX_SAMPLES)
            begin
                cur_geno[samp_cnt] = wd.genotype;
                weights[samp_cnt] = wd.sample_weight;
                samp_cnt++;
            end
            if (!wd.last_sample)
                return;
            trunc = 1'b0;
            pos_min = longint'({32'd0, cur_pos}) - longint'({32'd0, span_reg});
            for (int unsigned k = 1; k <= fill; k++)
            begin
                slot = (head + wwgc_pkg::WINDOW_COLS - k) % wwgc_pkg::WINDOW_COLS;
                if (longint'({32'd0, ring_pos[slot]}) < pos_min)
                    break;
                if (k == wwgc_pkg::WINDOW_COLS && dropped)
                    trunc = 1'b1;
                if (pair_corr(slot, q, neg) &&
                    longint'(q) * longint'(q) > (longint'(thr_reg) << 14))
                begin
                    mag = (!neg && q > 32767) ? 32767 : q;
                    o = '0;
                    o.neighbour_number = col_count - k + 1;
                    o.correlation = neg ? 16'(-mag) : 16'(mag);
                    o.pair_found = 1'b1;
                    col_words.insert(col_words.size(), o);
                end
            end
            if (col_words.size() == 0)
            begin
                o = '0;
                col_words.insert(0, o);
            end
            foreach (col_words[j])
                col_words[j].window_truncated = trunc;
            col_words[col_words.size() - 1].last_result = 1'b1;
            for (int unsigned i = 0; i < samp_cnt; i++)
                ring_geno[head][i] = cur_geno[i];
            ring_len[head] = samp_cnt;
            ring_pos[head] = cur_pos;
            head = (head + 1) % wwgc_pkg::WINDOW_COLS;
            if (fill < wwgc_pkg::WINDOW_COLS)
                fill++;
            else
                dropped = 1'b1;
            col_count++;
            samp_cnt = 0;
        end
    endfunction

    task automatic send_word(wwgc_pkg::in_word_t wd);
        int gap;
        begin
            gap = quiet_in ? 0 : $urandom_range(0, 10);
            @(negedge clk);
            if (gap > 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_valid = 1'b1;
            in_data = wd;
            do @(posedge clk); while (!in_ready);
            items++;
            take_word(wd);
        end
    endtask

    task automatic send_predicted(wwgc_pkg::in_word_t wd);
        begin
            send_word(wd);
            foreach (col_words[j])
                expected_words.insert(expected_words.size(), col_words[j]);
        end
    endtask

    task automatic drain();
        begin
            @(negedge clk);
            in_valid = 1'b0;
            while (expected_words.size() != 0)
                @(posedge clk);
        end
    endtask

    task automatic cfg_write(logic idx, logic [31:0] value);
        begin
            drain();
            @(negedge clk);
            in_valid = 1'b0;
            repeat (20) @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            @(negedge clk);
            cfg_valid = 1'b1;
            cfg_index = idx;
            cfg_data = value;
            do @(posedge clk); while (!cfg_ready);
            if (idx == wwgc_pkg::CFG_WINDOW_SPAN)
                span_reg = value;
            else
                thr_reg = value[15:0];
            @(negedge clk);
            cfg_valid = 1'b0;
        end
    endtask

    task automatic send_column(int len, logic [31:0] pos, bit related);
        wwgc_pkg::in_word_t wd;
        begin
            quiet_in = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < len; i++)
            begin
                wd.genotype = ($urandom_range(0, 9) == 0) ? wwgc_pkg::GENO_MISSING
                                                          : 2'($urandom_range(0, 2));
                if (related && i < 32 && $urandom_range(0, 4) != 0)
                    wd.genotype = prev_geno[i];
                if (i < 32)
                    prev_geno[i] = wd.genotype;
                wd.sample_weight = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom);
                wd.column_position = (i == 0) ? pos : 32'($urandom);
                wd.last_sample = (i == len - 1);
                send_predicted(wd);
            end
        end
    endtask

    task automatic run_phase(int budget, int max_len, int max_step, bit pause);
        logic [31:0] pos;
        int          start;
        begin
            pos = $urandom;
            start = items;
            while (items - start < budget)
            begin
                if ($urandom_range(0, 9) == 0)
                    pos = pos - $urandom_range(0, max_step);
                else
                    pos = pos + $urandom_range(0, max_step);
                send_column($urandom_range(1, max_len), pos, $urandom_range(0, 2) != 0);
                if (pause && items - start > budget / 2)
                begin
                    pause = 1'b0;
                    drain();
                end
            end
        end
    endtask

    // result side
    initial
    begin
        int gap;
        out_ready = 1'b0;
        quiet_out = 0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 19) == 0)
                quiet_out = !quiet_out;
            gap = quiet_out ? 0 : $urandom_range(0, 10);
            @(negedge clk);
            if (gap > 0)
            begin
                out_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
            if (expected_words.size() == 0)
                report("unexpected word", out_data.neighbour_number, 0);
            else
            begin
                wwgc_pkg::out_word_t want;
                want = expected_words.pop_front();
                if (out_data.neighbour_number !== want.neighbour_number)
                    report("neighbour_number", out_data.neighbour_number,
                           want.neighbour_number);
                if (out_data.correlation !== want.correlation)
                    report("correlation", 32'(out_data.correlation), 32'(want.correlation));
                if (out_data.pair_found !== want.pair_found)
                    report("pair_found", 32'(out_data.pair_found), 32'(want.pair_found));
                if (out_data.window_truncated !== want.window_truncated)
                    report("window_truncated", 32'(out_data.window_truncated),
                           32'(want.window_truncated));
                if (out_data.last_result !== want.last_result)
                    report("last_result", 32'(out_data.last_result), 32'(want.last_result));
            end
        end
    end

    // watchdog
    initial
    begin
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                idle = 0;
            else
                idle++;
            if (idle >= WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        wwgc_pkg::in_word_t wd;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = wwgc_pkg::CFG_WINDOW_SPAN;
        cfg_data = '0;
        errors = 0;
        items = 0;
        quiet_in = 0;
        span_reg = '0;
        thr_reg = wwgc_pkg::R2_THRESHOLD_RESET;
        col_count = '0;
        samp_cnt = 0;
        head = 0;
        fill = 0;
        dropped = 1'b0;
        cur_pos = '0;
        foreach (prev_geno[i])
            prev_geno[i] = '0;

        rows = '{
            '{'{2'd0, 16'd256, 32'd100, 1'b1}, 1'b1, '{32'd0, 16'sd0, 1'b0, 1'b0, 1'b1}},
            '{'{2'd0, 16'd256, 32'd100, 1'b0}, 1'b0, '0},
            '{'{2'd1, 16'd256, 32'd100, 1'b0}, 1'b0, '0},
            '{'{2'd2, 16'd256, 32'd100, 1'b1}, 1'b1, '{32'd0, 16'sd0, 1'b0, 1'b0, 1'b1}},
            '{'{2'd0, 16'd256, 32'd100, 1'b0}, 1'b0, '0},
            '{'{2'd1, 16'd256, 32'd100, 1'b0}, 1'b0, '0},
            '{'{2'd2, 16'd256, 32'd100, 1'b1}, 1'b1,
              '{32'd2, wwgc_pkg::CORR_POS_MAX, 1'b1, 1'b0, 1'b1}},
            '{'{2'd2, 16'd256, 32'd100, 1'b0}, 1'b0, '0},
            '{'{2'd1, 16'd256, 32'd100, 1'b0}, 1'b0, '0},
            '{'{2'd0, 16'd256, 32'd100, 1'b1}, 1'b0, '0},
            '{'{wwgc_pkg::GENO_MISSING, 16'hFFFF, 32'hFFFFFFFF, 1'b0}, 1'b0, '0},
            '{'{2'd0, 16'h0000, 32'hFFFFFFFF, 1'b0}, 1'b0, '0},
            '{'{2'd2, 16'hFFFF, 32'hFFFFFFFF, 1'b0}, 1'b0, '0},
            '{'{2'd1, 16'h1234, 32'hFFFFFFFF, 1'b1}, 1'b1, '{32'd0, 16'sd0, 1'b0, 1'b0, 1'b1}},
            '{'{wwgc_pkg::GENO_MISSING, 16'h0000, 32'd0, 1'b1}, 1'b1,
              '{32'd0, 16'sd0, 1'b0, 1'b0, 1'b1}}
        };

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[r])
        begin
            send_word(rows[r].word);
            if (rows[r].typed)
                expected_words.insert(expected_words.size(), rows[r].want);
            else
                foreach (col_words[j])
                    expected_words.insert(expected_words.size(), col_words[j]);
        end

        // oversized column: samples past the store are dropped
        quiet_in = 1;
        for (int i = 0; i < wwgc_pkg::MAX_SAMPLES + 4; i++)
        begin
            wd.genotype = 2'($urandom_range(0, 3));
            wd.sample_weight = 16'($urandom);
            wd.column_position = 32'h8000_0000;
            wd.last_sample = (i == wwgc_pkg::MAX_SAMPLES + 3);
            send_word(wd);
            items--;
            foreach (col_words[j])
                expected_words.insert(expected_words.size(), col_words[j]);
        end

        cfg_write(wwgc_pkg::CFG_WINDOW_SPAN, 32'hFFFF_FFFF);
        cfg_write(wwgc_pkg::CFG_R2_THRESHOLD, 32'd0);
        run_phase(95, 2, 1000, 1'b1);

        cfg_write(wwgc_pkg::CFG_WINDOW_SPAN, $urandom_range(0, 60));
        cfg_write(wwgc_pkg::CFG_R2_THRESHOLD, $urandom_range(0, 65535));
        run_phase(30, 8, 20, 1'b0);

        cfg_write(wwgc_pkg::CFG_WINDOW_SPAN, 32'd0);
        cfg_write(wwgc_pkg::CFG_R2_THRESHOLD, 32'd65535);
        run_phase(20, 6, 2, 1'b0);

        cfg_write(wwgc_pkg::CFG_WINDOW_SPAN, 32'hFFFF_FFFF);
        cfg_write(wwgc_pkg::CFG_R2_THRESHOLD, 32'(wwgc_pkg::R2_THRESHOLD_RESET));
        run_phase(25, 12, 50, 1'b0);

        @(negedge clk);
        in_valid = 1'b0;
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
